// ===== hw/rtl/alpp_pkg.sv =====
// Shared types and constants of the AT response line parser.
package alpp_pkg;

  // Item kinds carried in tuser on the request side
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Store selectors for read requests
  localparam logic [1:0] FIELD_QUAL  = 2'd0;
  localparam logic [1:0] FIELD_NAME  = 2'd1;
  localparam logic [1:0] FIELD_CLOCK = 2'd2;

  // Response kinds
  localparam logic [1:0] RESP_NONE  = 2'd0;
  localparam logic [1:0] RESP_QUAL  = 2'd1;
  localparam logic [1:0] RESP_NAME  = 2'd2;
  localparam logic [1:0] RESP_CLOCK = 2'd3;

  // Characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_Q     = 8'h51;
  localparam logic [7:0] CHAR_S     = 8'h53;

  // Line positions mirrored in flops for prefix matching
  localparam int HEAD_LEN = 6;

  // Text store: quality, name and clock share one memory
  localparam int QUAL_DEPTH     = 4;
  localparam int TEXT_DEPTH     = 42;
  localparam int TEXT_MEM_DEPTH = QUAL_DEPTH + 2 * TEXT_DEPTH;
  localparam int TEXT_AW        = $clog2(TEXT_MEM_DEPTH);

  localparam logic [TEXT_AW-1:0] QUAL_BASE  = TEXT_AW'(0);
  localparam logic [TEXT_AW-1:0] NAME_BASE  = TEXT_AW'(QUAL_DEPTH);
  localparam logic [TEXT_AW-1:0] CLOCK_BASE = TEXT_AW'(QUAL_DEPTH + TEXT_DEPTH);

  // Copy windows within the line
  localparam logic [5:0] QUAL_FIRST = 6'd6;
  localparam logic [5:0] QUAL_SPAN  = 6'd4;
  localparam logic [5:0] TEXT_FIRST = 6'd8;
  localparam logic [5:0] TEXT_SPAN  = 6'd42;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic [1:0] read_field;
    logic [5:0] read_index;
  } alpp_item_t;

  typedef struct packed {
    logic       line_ended;
    logic [1:0] response_kind;
    logic [5:0] copied_count;
    logic       ok_at_start;
    logic [7:0] read_char;
  } alpp_result_t;

endpackage

// ===== hw/rtl/alpp_zmem.sv =====
// Single-port-write, single-port-read memory whose unwritten entries read as zero.
module alpp_zmem #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_q <= valid[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : 8'h00;

endmodule

// ===== hw/rtl/alpp_ctrl.sv =====
// Sequencer: line append, prefix match, copy walk and result register.
module alpp_ctrl #(
  parameter int LINE_CAPACITY = 64,
  parameter int LINE_AW       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  alpp_pkg::alpp_item_t        item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output alpp_pkg::alpp_result_t      result,
  output logic                        line_we,
  output logic [LINE_AW-1:0]          line_waddr,
  output logic [7:0]                  line_wdata,
  output logic [LINE_AW-1:0]          line_raddr,
  input  logic [7:0]                  line_rdata,
  output logic                        text_we,
  output logic [alpp_pkg::TEXT_AW-1:0] text_waddr,
  output logic [7:0]                  text_wdata,
  output logic [alpp_pkg::TEXT_AW-1:0] text_raddr,
  input  logic [7:0]                  text_rdata
);
  import alpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_COPY   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t             state;
  logic [LINE_AW-1:0] line_length;
  logic [7:0]         head [HEAD_LEN];
  logic [LINE_AW-1:0] cp_first;
  logic [5:0]         cp_span;
  logic [7:0]         cp_stop;
  logic [TEXT_AW-1:0] cp_base;
  logic [5:0]         iss;
  logic [5:0]         cnt;
  logic               pend;
  logic               res_ended;
  logic [1:0]         res_kind;
  logic               rd_hit;
  logic [TEXT_AW-1:0] rd_addr;

  logic               accept;
  logic               is_eol;
  logic               rd_hit_c;
  logic [TEXT_AW-1:0] rd_base;
  logic [TEXT_AW-1:0] rd_addr_c;
  logic               got;
  logic               done;
  logic               issue;
  logic [5:0]         cnt_p1;
  logic               m_csq;
  logic               m_qspn;
  logic               m_cclk;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_eol   = (item.rx_byte == CHAR_CR) || (item.rx_byte == CHAR_LF);

  // Append or terminate the line on accept
  always_comb begin
    line_we    = 1'b0;
    line_waddr = line_length;
    line_wdata = item.rx_byte;
    if (accept && item.kind == KIND_BYTE && item.rx_byte != CHAR_NUL) begin
      if (is_eol) begin
        line_we    = 1'b1;
        line_wdata = CHAR_NUL;
      end else if (line_length < LINE_AW'(LINE_CAPACITY)) begin
        line_we = 1'b1;
      end
    end
  end

  // Read request address into the text memory
  always_comb begin
    unique case (item.read_field)
      FIELD_QUAL: begin
        rd_hit_c = (item.read_index < 6'(QUAL_DEPTH));
        rd_base  = QUAL_BASE;
      end
      FIELD_NAME: begin
        rd_hit_c = (item.read_index < 6'(TEXT_DEPTH));
        rd_base  = NAME_BASE;
      end
      FIELD_CLOCK: begin
        rd_hit_c = (item.read_index < 6'(TEXT_DEPTH));
        rd_base  = CLOCK_BASE;
      end
      default: begin
        rd_hit_c = 1'b0;
        rd_base  = QUAL_BASE;
      end
    endcase
    rd_addr_c = rd_hit_c ? (rd_base + TEXT_AW'(item.read_index)) : QUAL_BASE;
    // Hold the read address while the request waits for the result register
    text_raddr = (state == S_IDLE) ? rd_addr_c : rd_addr;
  end

  // Copy walk: one line read issued per cycle, its data checked in the cycle after
  assign cnt_p1     = cnt + 6'd1;
  assign got        = pend && (line_rdata != cp_stop);
  assign done       = pend && (!got || cnt_p1 == cp_span);
  assign issue      = (state == S_COPY) && (iss < cp_span) && !done;
  assign line_raddr = cp_first + LINE_AW'(iss);
  assign text_we    = (state == S_COPY) && got;
  assign text_waddr = cp_base + TEXT_AW'(cnt);
  assign text_wdata = line_rdata;

  assign m_csq  = head[0] == CHAR_PLUS && head[1] == CHAR_C && head[2] == CHAR_S
               && head[3] == CHAR_Q && head[4] == CHAR_COLON;
  assign m_qspn = head[0] == CHAR_PLUS && head[1] == CHAR_Q && head[2] == CHAR_S
               && head[3] == CHAR_P && head[4] == CHAR_N && head[5] == CHAR_COLON;
  assign m_cclk = head[0] == CHAR_PLUS && head[1] == CHAR_C && head[2] == CHAR_C
               && head[3] == CHAR_L && head[4] == CHAR_K && head[5] == CHAR_COLON;

  // Mirror of the first line positions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEAD_LEN; i++) begin
        head[i] <= CHAR_NUL;
      end
    end else if (line_we && line_waddr < LINE_AW'(HEAD_LEN)) begin
      head[line_waddr[2:0]] <= line_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_length <= '0;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_ended <= 1'b0;
            res_kind  <= RESP_NONE;
            cnt       <= '0;
            rd_hit    <= (item.kind == KIND_READ) && rd_hit_c;
            rd_addr   <= rd_addr_c;
            state     <= S_FINISH;
            if (line_we) begin
              if (is_eol) begin
                line_length <= '0;
                res_ended   <= 1'b1;
                state       <= S_MATCH;
              end else begin
                line_length <= line_length + LINE_AW'(1);
              end
            end
          end
        end
        S_MATCH: begin
          iss   <= '0;
          pend  <= 1'b0;
          state <= S_COPY;
          priority if (m_csq) begin
            res_kind <= RESP_QUAL;
            cp_first <= LINE_AW'(QUAL_FIRST);
            cp_span  <= QUAL_SPAN;
            cp_stop  <= CHAR_COMMA;
            cp_base  <= QUAL_BASE;
          end else if (m_qspn) begin
            res_kind <= RESP_NAME;
            cp_first <= LINE_AW'(TEXT_FIRST);
            cp_span  <= TEXT_SPAN;
            cp_stop  <= CHAR_QUOTE;
            cp_base  <= NAME_BASE;
          end else if (m_cclk) begin
            res_kind <= RESP_CLOCK;
            cp_first <= LINE_AW'(TEXT_FIRST);
            cp_span  <= TEXT_SPAN;
            cp_stop  <= CHAR_QUOTE;
            cp_base  <= CLOCK_BASE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_COPY: begin
          pend <= issue;
          if (issue) begin
            iss <= iss + 6'd1;
          end
          if (got) begin
            cnt <= cnt_p1;
          end
          if (done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the result register is free
          if (!out_valid || out_ready) begin
            result.line_ended    <= res_ended;
            result.response_kind <= res_kind;
            result.copied_count  <= cnt;
            result.ok_at_start   <= (head[0] == CHAR_O) && (head[1] == CHAR_K);
            result.read_char     <= rd_hit ? text_rdata : CHAR_NUL;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/at_response_line_parser_unit.sv =====
// Top level of the AT response line parser: sequencer plus line and text memories.
//
//  port group  dir  tdata (low bit up)                               tuser          tlast
//  s_*         in   rx_byte[7:0] read_field[9:8] read_index[15:10]   kind           -
//  m_*         out  copied_count[5:0] ok_at_start[6] read_char[14:7] response_kind  line_ended
//
// A byte or read request passes from idle to the finish state, where its result is
// registered once the output register is free; a line end also passes the prefix
// match and, on a matching prefix, the copy walk, which reads the line memory one
// entry per cycle up to the stop character or the end of the copy window.
// Reset clears the memories' valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only at its own result if m_tready stays low.
module at_response_line_parser_unit #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // rx_byte, read_field, read_index
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // copied_count, ok_at_start, read_char
  output logic [1:0]  m_tuser,  // response_kind
  output logic        m_tlast   // line_ended
);
  import alpp_pkg::*;

  localparam int LINE_DEPTH = LINE_CAPACITY + 1;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  alpp_item_t         item;
  alpp_result_t       result;
  logic               line_we;
  logic [LINE_AW-1:0] line_waddr;
  logic [7:0]         line_wdata;
  logic [LINE_AW-1:0] line_raddr;
  logic [7:0]         line_rdata;
  logic               text_we;
  logic [TEXT_AW-1:0] text_waddr;
  logic [7:0]         text_wdata;
  logic [TEXT_AW-1:0] text_raddr;
  logic [7:0]         text_rdata;

  assign item.kind       = s_tuser;
  assign item.rx_byte    = s_tdata[7:0];
  assign item.read_field = s_tdata[9:8];
  assign item.read_index = s_tdata[15:10];

  assign m_tdata = {1'b0, result.read_char, result.ok_at_start, result.copied_count};
  assign m_tuser = result.response_kind;
  assign m_tlast = result.line_ended;

  alpp_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .LINE_AW       (LINE_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata),
    .text_we    (text_we),
    .text_waddr (text_waddr),
    .text_wdata (text_wdata),
    .text_raddr (text_raddr),
    .text_rdata (text_rdata)
  );

  alpp_zmem #(
    .DEPTH (LINE_DEPTH),
    .AW    (LINE_AW)
  ) u_line_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  alpp_zmem #(
    .DEPTH (TEXT_MEM_DEPTH),
    .AW    (TEXT_AW)
  ) u_text_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (text_wdata),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the AT response line parser: line parsing, store reads, flow control.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alpp_pkg::*;

  localparam int LINE_CAPACITY = 64;
  localparam int LINE_DEPTH    = LINE_CAPACITY + 1;
  localparam int TOTAL_ITEMS   = 1050;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 60;
  localparam logic [1:0] FIELD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = KIND_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // mirror of the block's line and text stores
  logic [7:0] line_buf [LINE_DEPTH];
  int         line_len;
  logic [7:0] qual_text [QUAL_DEPTH];
  logic [7:0] name_text [TEXT_DEPTH];
  logic [7:0] clock_text [TEXT_DEPTH];

  alpp_result_t expected_results[$];
  int  requests_sent = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  idling_on = 1'b1;
  bit  long_hold = 1'b0;

  at_response_line_parser_unit #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit line_starts_with(string p);
    for (int k = 0; k < p.len(); k++) begin
      if (line_buf[k] != p[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // copy a window of the line into one store until the stop character or the window's end
  function automatic int copy_window(logic [1:0] dst, int first, int span, logic [7:0] stop);
    int n = 0;
    while (n < span && first + n < LINE_DEPTH && line_buf[first + n] != stop) begin
      case (dst)
        RESP_QUAL: qual_text[n] = line_buf[first + n];
        RESP_NAME: name_text[n] = line_buf[first + n];
        default:   clock_text[n] = line_buf[first + n];
      endcase
      n++;
    end
    return n;
  endfunction

  function automatic alpp_result_t parse_modem_item(alpp_item_t it);
    alpp_result_t r;
    int idx;
    r = '0;
    idx = int'(it.read_index);
    if (it.kind == KIND_READ) begin
      case (it.read_field)
        FIELD_QUAL:  if (idx < QUAL_DEPTH) r.read_char = qual_text[idx];
        FIELD_NAME:  if (idx < TEXT_DEPTH) r.read_char = name_text[idx];
        FIELD_CLOCK: if (idx < TEXT_DEPTH) r.read_char = clock_text[idx];
        default: ;
      endcase
    end else if (it.rx_byte != CHAR_NUL) begin
      if (it.rx_byte == CHAR_CR || it.rx_byte == CHAR_LF) begin
        // terminate but keep stale bytes past the terminator
        if (line_len < LINE_DEPTH) line_buf[line_len] = CHAR_NUL;
        line_len = 0;
        r.line_ended = 1'b1;
        if (line_starts_with("+CSQ:")) begin
          r.response_kind = RESP_QUAL;
          r.copied_count = 6'(copy_window(RESP_QUAL, int'(QUAL_FIRST), int'(QUAL_SPAN),
                                          CHAR_COMMA));
        end else if (line_starts_with("+QSPN:")) begin
          r.response_kind = RESP_NAME;
          r.copied_count = 6'(copy_window(RESP_NAME, int'(TEXT_FIRST), int'(TEXT_SPAN),
                                          CHAR_QUOTE));
        end else if (line_starts_with("+CCLK:")) begin
          r.response_kind = RESP_CLOCK;
          r.copied_count = 6'(copy_window(RESP_CLOCK, int'(TEXT_FIRST), int'(TEXT_SPAN),
                                          CHAR_QUOTE));
        end
      end else if (line_len < LINE_CAPACITY) begin
        line_buf[line_len] = it.rx_byte;
        line_len++;
      end
    end
    r.ok_at_start = (line_buf[0] == CHAR_O && line_buf[1] == CHAR_K);
    return r;
  endfunction

  task automatic send_request(logic kind, logic [7:0] b, logic [1:0] f, logic [5:0] i);
    int gap;
    alpp_item_t it;
    gap = pick_gap();
    it.kind = kind;
    it.rx_byte = b;
    it.read_field = f;
    it.read_index = i;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {i, f, b};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(parse_modem_item(it));
    requests_sent++;
  endtask

  task automatic feed_char(logic [7:0] b);
    send_request(KIND_BYTE, b, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
  endtask

  task automatic feed_text(string s);
    for (int k = 0; k < s.len(); k++) feed_char(s[k]);
  endtask

  task automatic query_store(logic [1:0] f, logic [5:0] i);
    send_request(KIND_READ, 8'($urandom_range(0, 255)), f, i);
  endtask

  task automatic end_line();
    case ($urandom_range(0, 2))
      0: feed_char(CHAR_CR);
      1: feed_char(CHAR_LF);
      default: begin
        feed_char(CHAR_CR);
        feed_char(CHAR_LF);
      end
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_CR || c == CHAR_LF);
    end else begin
      c = 8'($urandom_range(32, 126));
    end
    return c;
  endfunction

  task automatic test_reset_reads();
    query_store(FIELD_QUAL, 6'd0);
    query_store(FIELD_NAME, 6'd41);
    query_store(FIELD_CLOCK, 6'd42);
    query_store(FIELD_UNUSED, 6'd63);
  endtask

  task automatic test_special_lines();
    feed_char(CHAR_NUL);
    feed_text("OK");
    feed_char(CHAR_LF);
    // quality prefix with a comma right at the first copy position
    feed_text("+CSQ:7,");
    feed_char(CHAR_CR);
    query_store(FIELD_QUAL, 6'd0);
    // empty line puts its terminator at the first line position
    feed_char(CHAR_CR);
    feed_char(8'hFF);
    feed_char(CHAR_LF);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    feed_text("+QSPN: \"");
    for (int k = 0; k < 20; k++) feed_char(line_char());
    feed_char(CHAR_QUOTE);
    feed_char(CHAR_CR);
    query_store(FIELD_NAME, 6'd0);
  endtask

  task automatic test_drain_pause();
    feed_text("+CCLK: \"00/00/00,00:00:00+00\"");
    feed_char(CHAR_LF);
    wait_drained();
    query_store(FIELD_CLOCK, 6'd3);
  endtask

  task automatic test_random_traffic();
    int pick;
    int n;
    while (requests_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) idling_on = !idling_on;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        feed_text("+CSQ:");
        feed_char($urandom_range(0, 3) == 0 ? line_char() : 8'h20);
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) feed_char(8'($urandom_range(48, 57)));
        if ($urandom_range(0, 2) != 0) feed_text(",99");
        end_line();
      end else if (pick < 55) begin
        feed_text(pick < 38 ? "+QSPN:" : "+CCLK:");
        feed_char(8'h20);
        feed_char($urandom_range(0, 4) == 0 ? line_char() : CHAR_QUOTE);
        n = $urandom_range(0, 50);
        for (int k = 0; k < n; k++) feed_char(line_char());
        if ($urandom_range(0, 2) != 0) feed_char(CHAR_QUOTE);
        if ($urandom_range(0, 3) == 0) feed_text(",0,1");
        end_line();
      end else if (pick < 62) begin
        feed_text("OK");
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) feed_char(line_char());
        end_line();
      end else if (pick < 69) begin
        // lines near and past the line capacity
        n = $urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 8);
        for (int k = 0; k < n; k++) feed_char(line_char());
        end_line();
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          query_store(2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0 ?
                      6'($urandom_range(0, TEXT_DEPTH - 1)) : 6'($urandom_range(0, 63)));
        end
      end else if (pick < 92) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) feed_char(8'($urandom_range(0, 255)));
      end else begin
        // broken prefix
        if (pick < 96) begin
          feed_text("+CS");
        end else begin
          feed_text("+QSP");
        end
        n = $urandom_range(0, 10);
        for (int k = 0; k < n; k++) feed_char(line_char());
        end_line();
      end
    end
  endtask

  initial begin
    for (int k = 0; k < LINE_DEPTH; k++) line_buf[k] = CHAR_NUL;
    for (int k = 0; k < QUAL_DEPTH; k++) qual_text[k] = CHAR_NUL;
    for (int k = 0; k < TEXT_DEPTH; k++) begin
      name_text[k] = CHAR_NUL;
      clock_text[k] = CHAR_NUL;
    end
    line_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_reads();
    test_special_lines();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("at_response_line_parser_unit verification clean");
    end else begin
      $display("at_response_line_parser_unit verification failed");
    end
    $finish;
  end

  // result side ready: random stalls, plus one long hold-off on request
  initial begin : sink_ready
    int stall;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    alpp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: tdata %h tuser %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tlast !== want.line_ended) begin
          $error("line_ended expected %0d actual %0d", want.line_ended, m_tlast);
          errors++;
        end
        if (m_tuser !== want.response_kind) begin
          $error("response_kind expected %0d actual %0d", want.response_kind, m_tuser);
          errors++;
        end
        if (m_tdata[5:0] !== want.copied_count) begin
          $error("copied_count expected %0d actual %0d", want.copied_count, m_tdata[5:0]);
          errors++;
        end
        if (m_tdata[6] !== want.ok_at_start) begin
          $error("ok_at_start expected %0d actual %0d", want.ok_at_start, m_tdata[6]);
          errors++;
        end
        if (m_tdata[14:7] !== want.read_char) begin
          $error("read_char expected %h actual %h", want.read_char, m_tdata[14:7]);
          errors++;
        end
      end
    end
  end

  // end the run when neither side moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("at_response_line_parser_unit verification failed");
      $finish;
    end
  end

endmodule
